>>> rtl/assert_macros.svh
// assertion macros shared by the prefetcher modules
// each user module has clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define SSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold
`define SSP_ASSERT_NEVER(label, cond, msg) \
  `SSP_ASSERT(label, !(cond), msg)

`endif

>>> rtl/ssp_pkg.sv
// shared types, widths and codes for the stream stride prefetcher
// no dependencies
package ssp_pkg;

  localparam int ADDR_W = 64;
  localparam int TIME_W = 64;
  localparam int DEG_W  = 5;

  localparam int STREAM_COUNT_DEF = 16;
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int MAX_DEGREE       = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // distances at or above this never count as a match
  localparam logic [ADDR_W-1:0] DIST_LIMIT = 64'h7fff_ffff_ffff_ffff;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_PREFETCH_DEGREE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAGE_CLIP       = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] access_address;
    logic [TIME_W-1:0] access_time;
  } access_t;

  typedef struct packed {
    logic [ADDR_W-1:0] target_address;
    logic              last_of_run;
  } prefetch_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_SCAN,
    FRONT_DECIDE
  } front_state_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_t;

endpackage

>>> rtl/ssp_front.sv
// front end: accepts access words, scans the stream table, updates or allocates
// depends on ssp_pkg and assert_macros.svh
`include "assert_macros.svh"

module ssp_front
  import ssp_pkg::*;
#(
  parameter int STREAM_COUNT = STREAM_COUNT_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  localparam int SW = $clog2(PAGE_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  access_t           in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output logic [ADDR_W-1:0] job_address,
  output logic [SW-1:0]     job_stride
);

  localparam int IW = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
  localparam int CW = $clog2(STREAM_COUNT + 1);

  front_state_t state, state_next;

  access_t           acc;
  logic [CW-1:0]     cnt;
  logic              cmp_vld;
  logic [IW-1:0]     cmp_idx;
  logic [ADDR_W-1:0] rd_address;
  logic [TIME_W-1:0] rd_recency;
  logic [ADDR_W-1:0] best;
  logic [IW-1:0]     best_idx;
  logic              have_free;
  logic [IW-1:0]     free_idx;
  logic [TIME_W-1:0] oldest;
  logic [IW-1:0]     victim_idx;
  logic [STREAM_COUNT-1:0] stream_valid;

  logic [ADDR_W-1:0] address_mem [STREAM_COUNT];
  logic [TIME_W-1:0] recency_mem [STREAM_COUNT];

  logic [ADDR_W-1:0] fwd_gap;
  logic              matched;
  logic              issue;
  logic              scan_done;
  logic              in_accept;
  logic              wr_en;
  logic [IW-1:0]     wr_idx;

  assign fwd_gap   = acc.access_address - rd_address;
  assign matched   = (best != '0) && (best < ADDR_W'(PAGE_BYTES));
  assign issue     = (state == FRONT_SCAN) && (cnt < CW'(STREAM_COUNT));
  assign scan_done = (state == FRONT_SCAN) && (cnt == CW'(STREAM_COUNT)) && !cmp_vld;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      FRONT_IDLE:   if (in_valid) state_next = FRONT_SCAN;
      FRONT_SCAN:   if (scan_done) state_next = FRONT_DECIDE;
      FRONT_DECIDE: if (!matched || job_ready) state_next = FRONT_IDLE;
      default:      state_next = FRONT_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    job_valid = 1'b0;
    wr_en     = 1'b0;
    unique case (state)
      FRONT_IDLE: in_ready = 1'b1;
      FRONT_SCAN: ;
      FRONT_DECIDE: begin
        job_valid = matched;
        wr_en     = !matched || job_ready;
      end
      default: ;
    endcase
  end

  // matched stream is updated in place, otherwise first free entry, else lru victim
  assign wr_idx      = matched ? best_idx : (have_free ? free_idx : victim_idx);
  assign job_address = acc.access_address;
  assign job_stride  = best[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= FRONT_IDLE;
      cmp_vld      <= 1'b0;
      stream_valid <= '0;
    end else begin
      state   <= state_next;
      cmp_vld <= issue;
      if (wr_en) stream_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      acc        <= in_data;
      cnt        <= '0;
      best       <= DIST_LIMIT;
      best_idx   <= '0;
      have_free  <= 1'b0;
      free_idx   <= '0;
      oldest     <= DIST_LIMIT;
      victim_idx <= '0;
    end
    if (issue) begin
      cnt     <= cnt + 1'b1;
      cmp_idx <= cnt[IW-1:0];
    end
    if (cmp_vld) begin
      if (stream_valid[cmp_idx] && (fwd_gap < best)) begin
        best     <= fwd_gap;
        best_idx <= cmp_idx;
      end
      if (!stream_valid[cmp_idx] && !have_free) begin
        have_free <= 1'b1;
        free_idx  <= cmp_idx;
      end
      if (rd_recency < oldest) begin
        oldest     <= rd_recency;
        victim_idx <= cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_address <= address_mem[cnt[IW-1:0]];
      rd_recency <= recency_mem[cnt[IW-1:0]];
    end
    if (wr_en) begin
      address_mem[wr_idx] <= acc.access_address;
      recency_mem[wr_idx] <= acc.access_time;
    end
  end

  `SSP_ASSERT(a_accept_starts_scan, in_accept |=> state == FRONT_SCAN, "accept did not start a scan")
  `SSP_ASSERT(a_match_is_valid, (state == FRONT_DECIDE && matched) |-> stream_valid[best_idx], "matched entry not valid")

endmodule

>>> rtl/ssp_queue.sv
// small fifo carrying stream jobs from the front end to the generator
// depends on ssp_pkg and assert_macros.svh
`include "assert_macros.svh"

module ssp_queue
  import ssp_pkg::*;
#(
  parameter int WIDTH = ADDR_W,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = (count < NW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  `SSP_ASSERT_NEVER(a_count_bound, count > NW'(DEPTH), "queue count beyond depth")

endmodule

>>> rtl/ssp_back.sv
// generator: walks address + (k+1)*stride for one job and emits prefetch words
// depends on ssp_pkg and assert_macros.svh
`include "assert_macros.svh"

module ssp_back
  import ssp_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  localparam int SW = $clog2(PAGE_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  logic [ADDR_W-1:0] job_address,
  input  logic [SW-1:0]     job_stride,
  input  logic [DEG_W-1:0]  prefetch_degree,
  input  logic              page_clip,
  output logic              out_valid,
  input  logic              out_ready,
  output prefetch_t         out_data
);

  localparam int PGW = ADDR_W - SW;

  back_state_t state, state_next;

  logic [ADDR_W-1:0] cand;
  logic [PGW-1:0]    base_page;
  logic [SW-1:0]     stride;
  logic [DEG_W-1:0]  k;

  logic [DEG_W-1:0]  deg_eff;
  logic [ADDR_W-1:0] step;
  logic              cand_keep;
  logic              step_keep;
  logic              go;
  logic              emit;
  logic              last;
  logic              finish;

  assign deg_eff = (prefetch_degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE)
                                                          : prefetch_degree;
  assign step      = cand + ADDR_W'(stride);
  assign cand_keep = !page_clip || (cand[ADDR_W-1:SW] == base_page);
  assign step_keep = !page_clip || (step[ADDR_W-1:SW] == base_page);

  // kept addresses form a prefix of the run, so one lookahead finds the last
  assign go     = (state == BACK_RUN) && (deg_eff != '0) && cand_keep;
  assign emit   = go && (!out_valid || out_ready);
  assign last   = (k == deg_eff - 1'b1) || !step_keep;
  assign finish = (state == BACK_RUN) && (!go || (emit && last));

  always_comb begin
    state_next = state;
    unique case (state)
      BACK_IDLE: if (job_valid) state_next = BACK_RUN;
      BACK_RUN:  if (finish) state_next = BACK_IDLE;
      default:   state_next = BACK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = 1'b0;
    unique case (state)
      BACK_IDLE: job_ready = 1'b1;
      BACK_RUN:  ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BACK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      cand      <= job_address + ADDR_W'(job_stride);
      base_page <= job_address[ADDR_W-1:SW];
      stride    <= job_stride;
      k         <= '0;
    end
    if (emit) begin
      out_data.target_address <= cand;
      out_data.last_of_run    <= last;
      cand                    <= step;
      k                       <= k + 1'b1;
    end
  end

  `SSP_ASSERT(a_count_in_degree, emit |-> k < deg_eff, "emitted past prefetch degree")
  `SSP_ASSERT(a_run_open, (out_valid && !out_data.last_of_run) |-> state == BACK_RUN, "run closed before last word")

endmodule

>>> rtl/stream_stride_prefetcher.sv
// stream stride prefetcher: one access word in, 0 to 16 prefetch words out
// the front end takes no new access until it is done with the last one; its table scan reads
// one entry per cycle through the table memory port; the generator emits one word a cycle while
// out_ready is high; an access passes the scan and decide states, the queue and the generator
// synchronous reset clears stream valid bits at once (no clearing pass), degree 1, page clip 1
module stream_stride_prefetcher
  import ssp_pkg::*;
#(
  parameter int STREAM_COUNT = STREAM_COUNT_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  access_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output prefetch_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DEG_W-1:0]       cfg_data
);

  localparam int SW = $clog2(PAGE_BYTES);

  logic [DEG_W-1:0]  prefetch_degree;
  logic              page_clip;

  logic              fj_valid;
  logic              fj_ready;
  logic [ADDR_W-1:0] fj_address;
  logic [SW-1:0]     fj_stride;
  logic              bj_valid;
  logic              bj_ready;
  logic [ADDR_W-1:0] bj_address;
  logic [SW-1:0]     bj_stride;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefetch_degree <= DEG_W'(1);
      page_clip       <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PREFETCH_DEGREE: prefetch_degree <= cfg_data;
        REG_PAGE_CLIP:       page_clip       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ssp_front #(
    .STREAM_COUNT (STREAM_COUNT),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .job_valid   (fj_valid),
    .job_ready   (fj_ready),
    .job_address (fj_address),
    .job_stride  (fj_stride)
  );

  ssp_queue #(
    .WIDTH (ADDR_W + SW),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_data  ({fj_address, fj_stride}),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_data   ({bj_address, bj_stride})
  );

  ssp_back #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (bj_valid),
    .job_ready       (bj_ready),
    .job_address     (bj_address),
    .job_stride      (bj_stride),
    .prefetch_degree (prefetch_degree),
    .page_clip       (page_clip),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

endmodule
